>>> sv/ald_pkg.sv
// Shared types and constants for the access log to delimited text converter.
package ald_pkg;

    localparam int unsigned ALD_QUEUE_DEPTH = 4;

    localparam logic [4:0] ALD_DATE_CAPTURE = 5'd20;
    localparam logic [4:0] ALD_DATE_WINDOW  = 5'd26;

    localparam logic [7:0] CHR_NEWLINE   = 8'd10;
    localparam logic [7:0] CHR_SPACE     = 8'h20;
    localparam logic [7:0] CHR_QUOTE     = 8'h22;
    localparam logic [7:0] CHR_BACKSLASH = 8'd92;
    localparam logic [7:0] CHR_LBRACKET  = 8'h5b;
    localparam logic [7:0] CHR_RBRACKET  = 8'h5d;
    localparam logic [7:0] CHR_BAR       = 8'h7c;
    localparam logic [7:0] CHR_DOT       = 8'h2e;
    localparam logic [7:0] CHR_SLASH     = 8'h2f;
    localparam logic [7:0] CHR_COLON     = 8'h3a;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } t_out_item;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_BYTE,
        KIND_PIPE,
        KIND_DATE
    } t_kind;

    typedef struct packed {
        logic             prefix_bs;
        t_kind            kind;
        logic [7:0]       data;
        logic [11:0][3:0] digits;
    } t_cmd;

endpackage

>>> sv/ald_queue.sv
// Short command queue between the classifying front end and the output back end.
module ald_queue
    import ald_pkg::*;
#(
    parameter int unsigned DEPTH = ALD_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_full,
    output logic o_empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    t_cmd          r_slot [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] n_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [PW-1:0] n_rd_ptr;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    assign o_full  = (r_count == FULL_COUNT);
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_SLOT) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_SLOT) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

>>> sv/ald_front.sv
// Front end: accepts log bytes, tracks line state and issues output commands.
module ald_front
    import ald_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  t_in_item    i_in_item,
    output logic        o_in_stall,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_data,
    input  logic        i_q_full,
    output logic        o_push,
    output t_cmd        o_cmd
);

    localparam logic [23:0] MONTH_NAME [12] = '{
        "Jan", "Feb", "Mar", "Apr", "May", "Jun",
        "Jul", "Aug", "Sep", "Oct", "Nov", "Dec"
    };

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic [7:0] two_digits(input logic [7:0] a, input logic [7:0] b);
        if (!is_digit(a)) begin
            two_digits = 8'h00;
        end else if (!is_digit(b)) begin
            two_digits = {4'd0, a[3:0]};
        end else begin
            two_digits = {a[3:0], b[3:0]};
        end
    endfunction

    function automatic logic [7:0] year_digits(input logic [7:0] y0, input logic [7:0] y1,
                                               input logic [7:0] y2, input logic [7:0] y3);
        if (!is_digit(y0)) begin
            year_digits = 8'h00;
        end else if (!is_digit(y1)) begin
            year_digits = {4'd0, y0[3:0]};
        end else if (!is_digit(y2)) begin
            year_digits = {y0[3:0], y1[3:0]};
        end else if (!is_digit(y3)) begin
            year_digits = {y1[3:0], y2[3:0]};
        end else begin
            year_digits = {y2[3:0], y3[3:0]};
        end
    endfunction

    function automatic logic [7:0] month_digits(input logic [23:0] name);
        month_digits = 8'h00;
        for (int m = 0; m < 12; m++) begin
            if (name == MONTH_NAME[m]) begin
                month_digits = (m < 9) ? {4'd0, 4'(m + 1)} : {4'd1, 4'(m - 9)};
            end
        end
    endfunction

    logic [31:0] r_start_line;
    logic [31:0] r_lines_done;
    logic [31:0] n_lines_done;
    logic        r_in_quote;
    logic        n_in_quote;
    logic        r_in_bracket;
    logic        n_in_bracket;
    logic        r_held_bs;
    logic        n_held_bs;
    logic [4:0]  r_date_pos;
    logic [4:0]  n_date_pos;
    logic [7:0]  r_date [20];

    logic        accept;
    logic        drop_line;
    logic [4:0]  pos;
    logic [7:0]  b;
    logic        nl;
    logic        capture;
    logic [7:0]  month_bcd;
    logic [7:0]  day_bcd;
    logic [7:0]  year_bcd;
    logic [7:0]  hour_bcd;
    logic [7:0]  min_bcd;
    logic [7:0]  sec_bcd;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign b          = i_in_item.in_byte;
    assign nl         = (b == CHR_NEWLINE);
    assign drop_line  = ({1'b0, r_lines_done} + 33'd1) < {1'b0, r_start_line};
    assign pos        = (r_date_pos > ALD_DATE_WINDOW) ? 5'd0 : r_date_pos;
    assign capture    = accept && !drop_line && (pos != 5'd0) && !nl
                        && (pos <= ALD_DATE_CAPTURE);

    assign month_bcd = month_digits({r_date[3], r_date[4], r_date[5]});
    assign day_bcd   = two_digits(r_date[0], r_date[1]);
    assign year_bcd  = year_digits(r_date[7], r_date[8], r_date[9], r_date[10]);
    assign hour_bcd  = two_digits(r_date[12], r_date[13]);
    assign min_bcd   = two_digits(r_date[15], r_date[16]);
    assign sec_bcd   = two_digits(r_date[18], b);

    always_comb begin
        n_lines_done = r_lines_done;
        n_in_quote   = r_in_quote;
        n_in_bracket = r_in_bracket;
        n_held_bs    = r_held_bs;
        n_date_pos   = r_date_pos;
        o_push       = 1'b0;
        o_cmd        = '0;
        o_cmd.kind   = KIND_NONE;

        o_cmd.digits[0]  = month_bcd[7:4];
        o_cmd.digits[1]  = month_bcd[3:0];
        o_cmd.digits[2]  = day_bcd[7:4];
        o_cmd.digits[3]  = day_bcd[3:0];
        o_cmd.digits[4]  = year_bcd[7:4];
        o_cmd.digits[5]  = year_bcd[3:0];
        o_cmd.digits[6]  = hour_bcd[7:4];
        o_cmd.digits[7]  = hour_bcd[3:0];
        o_cmd.digits[8]  = min_bcd[7:4];
        o_cmd.digits[9]  = min_bcd[3:0];
        o_cmd.digits[10] = sec_bcd[7:4];
        o_cmd.digits[11] = sec_bcd[3:0];

        if (accept) begin
            if (drop_line) begin
                n_held_bs  = 1'b0;
                n_date_pos = 5'd0;
            end else if (pos != 5'd0) begin
                if (!nl) begin
                    if (pos == ALD_DATE_CAPTURE) begin
                        o_push     = 1'b1;
                        o_cmd.kind = KIND_DATE;
                    end
                    n_date_pos = (pos >= ALD_DATE_WINDOW) ? 5'd0 : pos + 5'd1;
                end
            end else begin
                n_held_bs       = 1'b0;
                o_cmd.prefix_bs = r_held_bs;
                o_cmd.data      = b;
                if (r_held_bs && (b == CHR_QUOTE)) begin
                    o_cmd.prefix_bs = 1'b0;
                    o_cmd.kind      = KIND_BYTE;
                    o_cmd.data      = CHR_DOT;
                end else if (b == CHR_QUOTE) begin
                    n_in_quote = !r_in_quote;
                end else if ((b == CHR_LBRACKET) && !r_in_quote) begin
                    n_in_bracket = 1'b1;
                    n_date_pos   = 5'd1;
                end else if ((b == CHR_RBRACKET) && !r_in_quote) begin
                    n_in_bracket = 1'b0;
                end else if (b == CHR_BACKSLASH) begin
                    if (i_in_item.end_of_input) begin
                        o_cmd.kind = KIND_BYTE;
                    end else begin
                        n_held_bs = 1'b1;
                    end
                end else if (b == CHR_SPACE) begin
                    o_cmd.kind = KIND_BYTE;
                    o_cmd.data = (r_in_quote || r_in_bracket) ? CHR_SPACE : CHR_BAR;
                end else if (b == CHR_BAR) begin
                    o_cmd.kind = KIND_PIPE;
                end else begin
                    o_cmd.kind = KIND_BYTE;
                end
                o_push = o_cmd.prefix_bs || (o_cmd.kind != KIND_NONE);
            end

            if (nl) begin
                n_in_quote   = 1'b0;
                n_in_bracket = 1'b0;
                n_held_bs    = 1'b0;
                n_date_pos   = 5'd0;
                n_lines_done = r_lines_done + 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_line <= '0;
            r_lines_done <= '0;
            r_in_quote   <= 1'b0;
            r_in_bracket <= 1'b0;
            r_held_bs    <= 1'b0;
            r_date_pos   <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_start_line <= i_cfg_data;
            end
            r_lines_done <= n_lines_done;
            r_in_quote   <= n_in_quote;
            r_in_bracket <= n_in_bracket;
            r_held_bs    <= n_held_bs;
            r_date_pos   <= n_date_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (capture) begin
            r_date[pos - 5'd1] <= b;
        end
    end

endmodule

>>> sv/ald_back.sv
// Back end: expands queued commands into output bytes through an output register.
module ald_back
    import ald_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_head,
    input  logic      i_q_empty,
    output logic      o_pop,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  logic      i_out_stall
);

    localparam logic [7:0] PIPE_TEXT [8] = '{"*", "*", "P", "I", "P", "E", "*", "*"};

    t_out_item  r_out_item;
    logic       r_out_valid;
    logic [4:0] r_idx;
    logic [4:0] body_j;
    logic       load;
    logic [7:0] gen_byte;
    logic       gen_last;
    logic [7:0] date_char;
    logic [3:0] digit_sel;
    logic       is_digit_pos;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign load        = !i_q_empty && (!r_out_valid || !i_out_stall);
    assign o_pop       = load && gen_last;
    assign body_j      = r_idx - {4'd0, i_head.prefix_bs};

    always_comb begin
        is_digit_pos = 1'b1;
        digit_sel    = 4'd0;
        date_char    = CHR_SLASH;
        case (body_j)
            5'd0:  digit_sel = 4'd0;
            5'd1:  digit_sel = 4'd1;
            5'd3:  digit_sel = 4'd2;
            5'd4:  digit_sel = 4'd3;
            5'd6:  digit_sel = 4'd4;
            5'd7:  digit_sel = 4'd5;
            5'd9:  digit_sel = 4'd6;
            5'd10: digit_sel = 4'd7;
            5'd12: digit_sel = 4'd8;
            5'd13: digit_sel = 4'd9;
            5'd15: digit_sel = 4'd10;
            5'd16: digit_sel = 4'd11;
            5'd8: begin
                is_digit_pos = 1'b0;
                date_char    = CHR_BAR;
            end
            5'd11, 5'd14: begin
                is_digit_pos = 1'b0;
                date_char    = CHR_COLON;
            end
            default: is_digit_pos = 1'b0;
        endcase
        if (is_digit_pos) begin
            date_char = {4'h3, i_head.digits[digit_sel]};
        end
    end

    always_comb begin
        if (i_head.prefix_bs && (r_idx == 5'd0)) begin
            gen_byte = CHR_BACKSLASH;
            gen_last = (i_head.kind == KIND_NONE);
        end else begin
            case (i_head.kind)
                KIND_PIPE: begin
                    gen_byte = PIPE_TEXT[body_j[2:0]];
                    gen_last = (body_j == 5'd7);
                end
                KIND_DATE: begin
                    gen_byte = date_char;
                    gen_last = (body_j == 5'd16);
                end
                default: begin
                    gen_byte = i_head.data;
                    gen_last = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_idx       <= gen_last ? 5'd0 : r_idx + 5'd1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_item.out_byte <= gen_byte;
            r_out_item.run_last <= gen_last;
        end
    end

endmodule

>>> sv/access_log_to_delimited_core.sv
// Top level of the access log to pipe-delimited text converter.
// The input channel carries one log byte per transaction with a flag on the final byte;
// a transaction completes on a clock edge where i_in_valid is high and o_in_stall is low.
// The output channel carries one converted byte per transaction, with run_last set on
// the last byte caused by each input byte; the receiver holds it with i_out_stall.
// The user writes the start line register through i_cfg_wr_en and i_cfg_data only
// while idle; the block itself does not enforce it. The front end classifies each byte
// in the cycle it arrives and places an output command in a queue of QUEUE_DEPTH
// entries; the back end expands each command into one to seventeen bytes, one per
// cycle while the receiver does not stall, into a registered output. An accepted
// byte's command is written into a queue slot before its first output byte is registered.
// One input byte is taken every cycle while each produces at most one output byte and
// the receiver does not stall; the back end's one byte per cycle sets the rate, and
// o_in_stall rises only when the queue is full.
// Input bytes that cause no output, such as dropped lines and date bytes, take no queue
// slot. When the receiver stalls, the output byte holds and the queue fills up.
// Reset clears all line state, the line count and the start line; no output is pending.
module access_log_to_delimited_core
    import ald_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = ALD_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  t_in_item    i_in_item,
    output logic        o_in_stall,
    output logic        o_out_valid,
    output t_out_item   o_out_item,
    input  logic        i_out_stall,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_data
);

    logic push;
    logic pop;
    logic q_full;
    logic q_empty;
    t_cmd cmd;
    t_cmd head;

    ald_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cmd       (cmd)
    );

    ald_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    ald_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_q_empty   (q_empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule
